// ----- rtl/symbol_frequency_table_sort_assert.svh -----
// Assertion macros for the symbol frequency table.
// Needs clk and rst_n in the including scope.
`ifndef SYMBOL_FREQUENCY_TABLE_SORT_ASSERT_SVH
`define SYMBOL_FREQUENCY_TABLE_SORT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ----- rtl/sfts_pkg.sv -----
// Shared constants, types and command/status bundles for the frequency table.
// No dependencies.
package sfts_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SYM_W = 8;
  localparam int FREQ_W = 32;
  localparam int DIST_W = 9;

  localparam logic [1:0] MODE_COUNT = 2'd0;
  localparam logic [1:0] MODE_SORT  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // table read address selects
  localparam logic [2:0] RA_MAP = 3'd0;
  localparam logic [2:0] RA_POS = 3'd1;
  localparam logic [2:0] RA_I   = 3'd2;
  localparam logic [2:0] RA_IM1 = 3'd3;
  localparam logic [2:0] RA_JM2 = 3'd4;

  typedef struct packed {
    logic [SYM_W-1:0]       sym;
    logic [COUNT_WIDTH-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic       ld_in;
    logic       cnt_lookup;
    logic       cnt_upd;
    logic       rd_out;
    logic       zero_out;
    logic       sort_init;
    logic       key_ld;
    logic       shift;
    logic       put;
    logic [2:0] raddr_sel;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic small_tab;
    logic gt;
    logic j_one;
    logic i_last;
  } stat_t;
endpackage

// ----- rtl/symbol_frequency_table_sort.sv -----
// Channel  | ports                                      | handshake
// input    | in_mode, in_symbol, in_position            | start && !busy
// result   | out_found, out_entry_symbol, out_frequency,| out_strobe, one cycle
//          | out_distinct                               |
// Count steps: map read, table read, table write; read: a table read;
// sort of an empty/one-entry table, an out-of-range read and unused mode give
// a zeroed result from the idle state. Sort of n entries: per key a key read,
// a compare and shift per shifted entry and a put, bounded by the single table RAM read port.
// Result strobes the cycle after the last step, busy low.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
// Top level: ties controller to datapath. Depends on sfts_pkg, sfts_ctrl,
// sfts_dp and the assertion header.
`include "symbol_frequency_table_sort_assert.svh"
module symbol_frequency_table_sort
  import sfts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [7:0]        in_position,
  output logic              out_strobe,
  output logic              out_found,
  output logic [SYM_W-1:0]  out_entry_symbol,
  output logic [FREQ_W-1:0] out_frequency,
  output logic [DIST_W-1:0] out_distinct
);
  cmd_t  cmd;
  stat_t stat;

  sfts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  sfts_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_symbol(in_symbol), .in_position(in_position),
    .out_strobe(out_strobe), .out_found(out_found),
    .out_entry_symbol(out_entry_symbol), .out_frequency(out_frequency),
    .out_distinct(out_distinct)
  );

  `ASSERT_NEVER(a_strobe_idle, out_strobe && busy, "result word while busy")
  `ASSERT_CLK(a_count_busy, start && !busy && in_mode == MODE_COUNT |=> busy, "count not started")
  `ASSERT_NEVER(a_distinct_max, out_distinct > DIST_W'(TABLE_DEPTH), "table overfilled")
endmodule

// ----- rtl/sfts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/sfts_dp.sv -----
// Datapath: table RAM (symbol, count), symbol-to-rank map RAM, sort indices
// and result registers. Depends on sfts_pkg and sfts_ram.
module sfts_dp
  import sfts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic [7:0]            in_position,
  output logic                  out_strobe,
  output logic                  out_found,
  output logic [SYM_W-1:0]      out_entry_symbol,
  output logic [FREQ_W-1:0]     out_frequency,
  output logic [DIST_W-1:0]     out_distinct
);
  logic [CNT_W-1:0]       distinct_r, distinct_nxt;
  logic [SYM_W-1:0]       sym_r;
  logic [IDX_W-1:0]       idx_r, i_r, j_r;
  logic                   inr_r;
  entry_t                 key_r, tab_q, tab_wdata;
  logic [IDX_W-1:0]       tab_raddr, tab_waddr, map_q, map_wdata;
  logic                   tab_we, map_we;
  logic [SYM_W-1:0]       map_waddr;
  logic [255:0]           map_ok_r;
  logic                   strobe_r, found_r;
  logic [SYM_W-1:0]       osym_r;
  logic [COUNT_WIDTH-1:0] ofreq_r, sat_cnt;
  logic [63:0]            freq_wide;
  logic                   hit, room;

  sfts_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_q)
  );

  // map RAM is indexed by symbol; an entry is trusted only if it was written
  // and points below the fill count at a row holding the same symbol
  sfts_ram #(.WIDTH(IDX_W), .DEPTH(256)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(in_symbol), .rdata(map_q)
  );

  assign sat_cnt = (&tab_q.cnt) ? tab_q.cnt : tab_q.cnt + 1'b1;
  assign hit     = inr_r && (tab_q.sym == sym_r);
  assign room    = distinct_r < CNT_W'(TABLE_DEPTH);

  always_comb begin
    unique case (cmd.raddr_sel)
      RA_MAP:  tab_raddr = map_q;
      RA_POS:  tab_raddr = in_position[IDX_W-1:0];
      RA_I:    tab_raddr = i_r;
      RA_IM1:  tab_raddr = i_r - 1'b1;
      RA_JM2:  tab_raddr = j_r - IDX_W'(2);
      default: tab_raddr = i_r;
    endcase
  end

  always_comb begin
    tab_we       = 1'b0;
    tab_waddr    = j_r;
    tab_wdata    = key_r;
    map_we       = 1'b0;
    map_waddr    = key_r.sym;
    map_wdata    = j_r;
    distinct_nxt = distinct_r;
    if (cmd.cnt_upd) begin
      if (hit) begin
        tab_we    = 1'b1;
        tab_waddr = idx_r;
        tab_wdata = '{sym: sym_r, cnt: sat_cnt};
      end else if (room) begin
        tab_we       = 1'b1;
        tab_waddr    = distinct_r[IDX_W-1:0];
        tab_wdata    = '{sym: sym_r, cnt: COUNT_WIDTH'(1)};
        map_we       = 1'b1;
        map_waddr    = sym_r;
        map_wdata    = distinct_r[IDX_W-1:0];
        distinct_nxt = distinct_r + 1'b1;
      end
    end else if (cmd.shift) begin
      tab_we    = 1'b1;
      tab_wdata = tab_q;
      map_we    = 1'b1;
      map_waddr = tab_q.sym;
    end else if (cmd.put) begin
      tab_we = 1'b1;
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distinct_r <= '0;
      strobe_r   <= 1'b0;
      map_ok_r   <= '0;
    end else begin
      distinct_r <= distinct_nxt;
      strobe_r   <= cmd.cnt_upd | cmd.rd_out | cmd.zero_out;
      if (map_we) begin
        map_ok_r[map_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      sym_r <= in_symbol;
    end
    if (cmd.cnt_lookup) begin
      idx_r <= map_q;
      inr_r <= map_ok_r[sym_r] && (CNT_W'(map_q) < distinct_r);
    end
    if (cmd.sort_init) begin
      i_r <= IDX_W'(1);
    end else if (cmd.put) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.key_ld) begin
      key_r <= tab_q;
      j_r   <= i_r;
    end else if (cmd.shift) begin
      j_r <= j_r - 1'b1;
    end
    if (cmd.cnt_upd) begin
      found_r <= hit;
      osym_r  <= sym_r;
      ofreq_r <= hit ? sat_cnt : (room ? COUNT_WIDTH'(1) : '0);
    end else if (cmd.rd_out) begin
      found_r <= 1'b1;
      osym_r  <= tab_q.sym;
      ofreq_r <= tab_q.cnt;
    end else if (cmd.zero_out) begin
      found_r <= 1'b0;
      osym_r  <= '0;
      ofreq_r <= '0;
    end
  end

  assign stat.pos_ok    = {1'b0, in_position} < DIST_W'(distinct_r);
  assign stat.small_tab = distinct_r < CNT_W'(2);
  assign stat.gt        = tab_q.cnt > key_r.cnt;
  assign stat.j_one     = j_r == IDX_W'(1);
  assign stat.i_last    = (CNT_W'(i_r) + 1'b1) == distinct_r;

  assign freq_wide        = 64'(ofreq_r);
  assign out_strobe       = strobe_r;
  assign out_found        = found_r;
  assign out_entry_symbol = osym_r;
  assign out_frequency    = freq_wide[FREQ_W-1:0];
  assign out_distinct     = DIST_W'(distinct_r);
endmodule

// ----- rtl/sfts_ctrl.sv -----
// Controller FSM sequencing count, read and insertion-sort operations.
// Depends on sfts_pkg.
module sfts_ctrl
  import sfts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CTAB  = 3'd1;
  localparam logic [2:0] ST_CUPD  = 3'd2;
  localparam logic [2:0] ST_ROUT  = 3'd3;
  localparam logic [2:0] ST_SKEY  = 3'd4;
  localparam logic [2:0] ST_SKEYL = 3'd5;
  localparam logic [2:0] ST_SCMP  = 3'd6;
  localparam logic [2:0] ST_SPUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.raddr_sel = RA_I;
    unique case (state_r)
      ST_IDLE: begin
        cmd.raddr_sel = RA_POS;
        if (start) begin
          cmd.ld_in = 1'b1;
          unique case (in_mode)
            MODE_COUNT: state_nxt = ST_CTAB;
            MODE_SORT: begin
              if (stat.small_tab) begin
                cmd.zero_out = 1'b1;
              end else begin
                cmd.sort_init = 1'b1;
                state_nxt     = ST_SKEY;
              end
            end
            MODE_READ: begin
              if (stat.pos_ok) state_nxt = ST_ROUT;
              else cmd.zero_out = 1'b1;
            end
            default: cmd.zero_out = 1'b1;
          endcase
        end
      end
      ST_CTAB: begin
        cmd.raddr_sel  = RA_MAP;
        cmd.cnt_lookup = 1'b1;
        state_nxt      = ST_CUPD;
      end
      ST_CUPD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_ROUT: begin
        cmd.rd_out = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SKEY: state_nxt = ST_SKEYL;
      ST_SKEYL: begin
        cmd.key_ld    = 1'b1;
        cmd.raddr_sel = RA_IM1;
        state_nxt     = ST_SCMP;
      end
      ST_SCMP: begin
        cmd.raddr_sel = RA_JM2;
        if (stat.gt) begin
          cmd.shift = 1'b1;
          if (stat.j_one) state_nxt = ST_SPUT;
        end else begin
          state_nxt = ST_SPUT;
        end
      end
      ST_SPUT: begin
        cmd.put = 1'b1;
        if (stat.i_last) begin
          cmd.zero_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_SKEY;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;
endmodule
